>>> rtl/core/cmrs_pkg.sv
`timescale 1ns / 1ps
// Package for the counting multiset rank/select unit: sizes, codes, state
// and payload types. Depends on nothing; cmrs_alu, cmrs_seq and the top level use it.
package cmrs_pkg;

   localparam int NUM_KEYS   = 1024;
   localparam int COUNT_BITS = 16;
   localparam int ADDR_BITS  = (NUM_KEYS > 2) ? $clog2(NUM_KEYS) : 1;
   localparam int SUM_BITS   = COUNT_BITS + ADDR_BITS;
   localparam int KEY_W      = 10;
   localparam int RANK_W     = 16;
   localparam int ALU_BITS   = (SUM_BITS > RANK_W) ? SUM_BITS : RANK_W;

   localparam logic [ADDR_BITS-1:0] LAST_KEY = ADDR_BITS'(NUM_KEYS - 1);

   localparam logic [1:0] ACT_REMOVE = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_SELECT = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_SEL
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [KEY_W-1:0]  key;
      logic [RANK_W-1:0] rank;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [KEY_W-1:0] found_key;
      logic             error;
   } rsp_type;

   typedef struct packed {
      alu_op_type          op;
      logic [ALU_BITS-1:0] a;
      logic [ALU_BITS-1:0] b;
      logic [ALU_BITS-1:0] thr;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_BITS-1:0] result;
      logic                ge;
   } alu_rsp_type;

endpackage

>>> rtl/core/cmrs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cmrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/cmrs_alu.sv
`timescale 1ns / 1ps
// Shared arithmetic unit: one add/subtract and one compare against a threshold.
// Depends on cmrs_pkg.
module cmrs_alu (
   input  cmrs_pkg::alu_req_type alu_req,
   output cmrs_pkg::alu_rsp_type alu_rsp
);

   logic [cmrs_pkg::ALU_BITS-1:0] result;

   always_comb begin
      if (alu_req.op == cmrs_pkg::ALU_ADD) begin
         result = alu_req.a + alu_req.b;
      end else begin
         result = alu_req.a - alu_req.b;
      end
   end

   assign alu_rsp.result = result;
   assign alu_rsp.ge     = (result >= alu_req.thr);

endmodule

>>> rtl/core/cmrs_seq.sv
`timescale 1ns / 1ps
// Sequencer: clearing pass, read-modify-write of one count, and the prefix walk.
// Drives the count RAM and the shared ALU. Depends on cmrs_pkg.
module cmrs_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  cmrs_pkg::req_type                 req_data,
   output logic                              busy,
   output logic                              rsp_strobe,
   output cmrs_pkg::rsp_type                 rsp_data,
   output logic                              ram_wr_en,
   output logic [cmrs_pkg::ADDR_BITS-1:0]    ram_wr_addr,
   output logic [cmrs_pkg::COUNT_BITS-1:0]   ram_wr_data,
   output logic [cmrs_pkg::ADDR_BITS-1:0]    ram_rd_addr,
   input  logic [cmrs_pkg::COUNT_BITS-1:0]   ram_rd_data,
   output cmrs_pkg::alu_req_type             alu_req,
   input  cmrs_pkg::alu_rsp_type             alu_rsp
);

   cmrs_pkg::state_type                state_ff, state_in;
   logic [cmrs_pkg::ADDR_BITS-1:0]     addr_ff, addr_in;
   logic [cmrs_pkg::ADDR_BITS-1:0]     dkey_ff, dkey_in;
   logic                               pend_ff, pend_in;
   logic [cmrs_pkg::SUM_BITS-1:0]      sum_ff, sum_in;
   cmrs_pkg::req_type                  req_ff, req_in;
   cmrs_pkg::rsp_type                  rsp_ff, rsp_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;

   logic accept;
   logic key_oor;
   logic [cmrs_pkg::ADDR_BITS-1:0] key_addr;

   assign accept   = start && (state_ff == cmrs_pkg::ST_IDLE);
   assign key_oor  = (32'(req_data.key) >= cmrs_pkg::NUM_KEYS);
   assign key_addr = cmrs_pkg::ADDR_BITS'(req_ff.key);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cmrs_pkg::ST_CLEAR: begin
            if (addr_ff == cmrs_pkg::LAST_KEY) begin
               state_in = cmrs_pkg::ST_IDLE;
            end
         end
         cmrs_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  cmrs_pkg::ACT_REMOVE, cmrs_pkg::ACT_INSERT: begin
                     state_in = key_oor ? cmrs_pkg::ST_IDLE : cmrs_pkg::ST_UPD_RD;
                  end
                  cmrs_pkg::ACT_SELECT: begin
                     state_in = cmrs_pkg::ST_SEL;
                  end
                  default: begin
                     state_in = cmrs_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         cmrs_pkg::ST_UPD_RD: begin
            state_in = cmrs_pkg::ST_UPD_WR;
         end
         cmrs_pkg::ST_UPD_WR: begin
            state_in = cmrs_pkg::ST_IDLE;
         end
         cmrs_pkg::ST_SEL: begin
            if (pend_ff && (alu_rsp.ge || (dkey_ff == cmrs_pkg::LAST_KEY))) begin
               state_in = cmrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cmrs_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM and ALU control.
   always_comb begin
      addr_in       = addr_ff;
      dkey_in       = dkey_ff;
      pend_in       = pend_ff;
      sum_in        = sum_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = key_addr;
      ram_wr_data   = cmrs_pkg::COUNT_BITS'(alu_rsp.result);
      ram_rd_addr   = key_addr;
      alu_req.op    = cmrs_pkg::ALU_ADD;
      alu_req.a     = cmrs_pkg::ALU_BITS'(ram_rd_data);
      alu_req.b     = cmrs_pkg::ALU_BITS'(1);
      alu_req.thr   = cmrs_pkg::ALU_BITS'(req_ff.rank);

      case (state_ff)
         cmrs_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff;
            ram_wr_data = '0;
            addr_in     = addr_ff + 1'b1;
         end
         cmrs_pkg::ST_IDLE: begin
            if (accept) begin
               req_in  = req_data;
               addr_in = '0;
               pend_in = 1'b0;
               sum_in  = '0;
               rsp_in  = '0;
               // Unused action codes and keys beyond the store answer at once.
               case (req_data.action)
                  cmrs_pkg::ACT_REMOVE, cmrs_pkg::ACT_INSERT: begin
                     if (key_oor) begin
                        rsp_in.error  = 1'b1;
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  cmrs_pkg::ACT_SELECT: begin
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         cmrs_pkg::ST_UPD_RD: begin
         end
         cmrs_pkg::ST_UPD_WR: begin
            rsp_in        = '0;
            rsp_strobe_in = 1'b1;
            if (req_ff.action == cmrs_pkg::ACT_REMOVE) begin
               alu_req.op = cmrs_pkg::ALU_SUB;
               if (ram_rd_data == '0) begin
                  rsp_in.error = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
               end
            end else begin
               if (ram_rd_data == '1) begin
                  rsp_in.error = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
               end
            end
         end
         cmrs_pkg::ST_SEL: begin
            // Reads run one key ahead of the running sum.
            ram_rd_addr = addr_ff;
            addr_in     = addr_ff + 1'b1;
            dkey_in     = addr_ff;
            pend_in     = 1'b1;
            alu_req.a   = cmrs_pkg::ALU_BITS'(sum_ff);
            alu_req.b   = cmrs_pkg::ALU_BITS'(ram_rd_data);
            if (pend_ff) begin
               sum_in = cmrs_pkg::SUM_BITS'(alu_rsp.result);
               if (alu_rsp.ge) begin
                  rsp_in.found     = 1'b1;
                  rsp_in.found_key = cmrs_pkg::KEY_W'(dkey_ff);
                  rsp_in.error     = 1'b0;
                  rsp_strobe_in    = 1'b1;
               end else if (dkey_ff == cmrs_pkg::LAST_KEY) begin
                  rsp_in        = '0;
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cmrs_pkg::ST_CLEAR;
         addr_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      dkey_ff <= dkey_in;
      sum_ff  <= sum_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != cmrs_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> rtl/core/counting_multiset_rank_select_unit.sv
`timescale 1ns / 1ps
// A histogram of counts over the key range, with insert, remove and rank select requests.
// Depends on cmrs_pkg, cmrs_ram, cmrs_alu and cmrs_seq.
//
// A request is taken when start is high and busy is low, and gives exactly one result,
// shown for one cycle with rsp_strobe; the receiver cannot stall it, so it must take
// every strobe. After reset the block clears its count store, one key a cycle, and is
// busy until every key is cleared. An insert or remove reads, updates and writes one
// count. A select walks the store from key 0 through the single read port of the count
// RAM, one key a cycle, with one shared adder building the running sum; it strobes a hit
// on the first key whose running sum reaches the rank, or a miss after the last key. An
// unused action code or a key outside the store strobes in the next cycle. A new request
// may be given in the strobe cycle.
module counting_multiset_rank_select_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cmrs_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output cmrs_pkg::rsp_type rsp_data
);

   logic                              ram_wr_en;
   logic [cmrs_pkg::ADDR_BITS-1:0]    ram_wr_addr;
   logic [cmrs_pkg::COUNT_BITS-1:0]   ram_wr_data;
   logic [cmrs_pkg::ADDR_BITS-1:0]    ram_rd_addr;
   logic [cmrs_pkg::COUNT_BITS-1:0]   ram_rd_data;
   cmrs_pkg::alu_req_type             alu_req;
   cmrs_pkg::alu_rsp_type             alu_rsp;

   cmrs_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_data    (req_data),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .alu_req     (alu_req),
      .alu_rsp     (alu_rsp)
   );

   cmrs_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   cmrs_ram #(
      .WIDTH (cmrs_pkg::COUNT_BITS),
      .DEPTH (cmrs_pkg::NUM_KEYS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A result is only ever presented once the sequencer is back at rest.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while the sequencer is busy");

   // An accepted request either keeps the block busy or answers at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request neither started nor answered");

   // A rejected update never reports a found key.
   a_error_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.error) |-> !rsp_data.found)
      else $error("result flags both error and found");

endmodule
